/* hdl/mcwp_pkg.sv */
package mcwp_pkg;

  // Field widths.
  localparam int WORD_W  = 32;
  localparam int SPEED_W = 14;
  localparam int FEED_W  = 20;
  localparam int BPP_W   = 8;
  // Holds a bitmap word count of up to 2^27 plus the two header steps.
  localparam int STEP_W  = 28;
  localparam int PROD_W  = 2 * SPEED_W;

  typedef logic signed [WORD_W-1:0] coord_t;

  // Command codes as they appear in the word stream.
  localparam coord_t CODE_TRAVEL  = 32'sd0;
  localparam coord_t CODE_LINE    = 32'sd1;
  localparam coord_t CODE_ZMOVE   = 32'sd2;
  localparam coord_t CODE_SETPOS  = 32'sd4;
  localparam coord_t CODE_SETTING = 32'sd7;
  localparam coord_t CODE_BITMAP  = 32'sd9;

  // Setting indexes.
  localparam coord_t SET_IDX_SPEED = 32'sd100;
  localparam coord_t SET_IDX_POWER = 32'sd101;

  // Mark speed percentage limits, in hundredths of a percent.
  localparam coord_t SPEED_PCT_MIN = 32'sd1;
  localparam coord_t SPEED_PCT_SAT = 32'sd9999;
  localparam logic [SPEED_W-1:0] SPEED_PCT_FULL = 14'd10000;

  // Division by 10000 as a multiplication by a rounded-up reciprocal.
  // Exact for every product below 2^28 since the rounding error is below 2^14.
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 42;
  localparam logic [RECIP_W-1:0] RECIP = 29'd439804652;

  localparam int FEED_SCALE = 60;
  localparam int BITS_PER_WORD_LOG2 = 5;

  // Reset values.
  localparam logic [SPEED_W-1:0] SPEED_RESET = 14'd100;
  localparam coord_t POWER_RESET = 32'sd10000;
  localparam coord_t CLAMP_MAX_RESET = 32'sh7FFF_FFFF;
  localparam logic [BPP_W-1:0] BPP_RESET = 8'd1;

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_BASE_SPEED   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BITMAP_SPEED = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP_EN     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP_MAX_X  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP_MAX_Y  = 3'd7;

  typedef enum logic [2:0] {
    CMD_TRAVEL,
    CMD_LINE,
    CMD_ZMOVE,
    CMD_SETPOS,
    CMD_SETTING,
    CMD_BITMAP,
    CMD_SKIP
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_SPEED,
    SEL_POWER
  } set_sel_e;

  typedef enum logic [1:0] {
    ACT_TRAVEL = 2'd0,
    ACT_LINE   = 2'd1,
    ACT_BITMAP = 2'd2
  } act_e;

  typedef enum logic {
    KIND_MOVE   = 1'b0,
    KIND_SETPOS = 1'b1
  } kind_e;

  // Request to the mark speed scaler.
  typedef struct packed {
    logic               load;
    logic [SPEED_W-1:0] percent;
    logic [SPEED_W-1:0] base;
  } speed_req_t;

  // Maps a code word to the command it starts; anything unknown is skipped.
  function automatic cmd_e decode_cmd(coord_t code);
    cmd_e cmd;
    case (code)
      CODE_TRAVEL:  cmd = CMD_TRAVEL;
      CODE_LINE:    cmd = CMD_LINE;
      CODE_ZMOVE:   cmd = CMD_ZMOVE;
      CODE_SETPOS:  cmd = CMD_SETPOS;
      CODE_SETTING: cmd = CMD_SETTING;
      CODE_BITMAP:  cmd = CMD_BITMAP;
      default:      cmd = CMD_SKIP;
    endcase
    return cmd;
  endfunction

endpackage

/* hdl/mcwp_clamp.sv */
module mcwp_clamp import mcwp_pkg::*; #(
  parameter logic signed [31:0] X_LOW  = 0,
  parameter logic signed [31:0] Y_LOW  = 0,
  parameter logic signed [31:0] Z_LOW  = 0,
  parameter logic signed [31:0] Z_HIGH = 0
) (
  input  logic   enable_i,
  input  coord_t max_x_i,
  input  coord_t max_y_i,
  input  coord_t x_i,
  input  coord_t y_i,
  input  coord_t z_i,
  output coord_t x_o,
  output coord_t y_o,
  output coord_t z_o
);

  // Raise to the lower limit first, then lower to the upper limit,
  // so the upper limit wins when the two cross.
  function automatic coord_t limit(coord_t v, coord_t lo, coord_t hi);
    coord_t r;
    r = (v < lo) ? lo : v;
    r = (hi < r) ? hi : r;
    return r;
  endfunction

  always_comb begin
    if (enable_i) begin
      x_o = limit(x_i, X_LOW, max_x_i);
      y_o = limit(y_i, Y_LOW, max_y_i);
      z_o = limit(z_i, Z_LOW, Z_HIGH);
    end else begin
      x_o = x_i;
      y_o = y_i;
      z_o = z_i;
    end
  end

endmodule

/* hdl/mcwp_speed_scale.sv */
module mcwp_speed_scale import mcwp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  speed_req_t         req_i,
  output logic [SPEED_W-1:0] line_speed_o
);

  logic                      load_q;
  logic [PROD_W-1:0]         prod_q;
  logic [PROD_W+RECIP_W-1:0] scaled;
  logic [SPEED_W-1:0]        line_speed_q;

  // First stage: percentage times the base speed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
    end else begin
      load_q <= req_i.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      prod_q <= PROD_W'(req_i.percent) * PROD_W'(req_i.base);
    end
  end

  // Second stage: divide by 10000 through the reciprocal.
  assign scaled = (PROD_W + RECIP_W)'(prod_q) * (PROD_W + RECIP_W)'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_speed_q <= SPEED_RESET;
    end else if (load_q) begin
      line_speed_q <= scaled[RECIP_SHIFT +: SPEED_W];
    end
  end

  assign line_speed_o = line_speed_q;

endmodule

/* hdl/mcwp_bitmap_store.sv */
module mcwp_bitmap_store import mcwp_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  logic   we_i,
  input  coord_t data_i
);

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] addr_q;
  coord_t        mem_q [DEPTH];

  // Write pointer restarts with each bitmap load and wraps at the depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (start_i) begin
      addr_q <= '0;
    end else if (we_i) begin
      addr_q <= (addr_q == AW'(DEPTH - 1)) ? '0 : addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_q] <= data_i;
    end
  end

endmodule

/* hdl/motion_command_word_parser_unit.sv */
// Command word parser for a laser motion controller. It takes one 32-bit word
// per cycle on the word channel while the result register is free or being
// read, a code followed by its arguments, and returns a move or set-position
// request after the last argument of a travel, laser line, z move or
// set-position command. Every word goes through an input register and the
// request is then registered in the output register; a full output register
// that is being read does not stop the next word. A new mark speed settles
// through its multiply pipeline before a following line command can use it.
// The configuration port is ready only while the input register is empty.
// Coordinates are relative to the configured origin and wrap at 32 bits.
module motion_command_word_parser_unit import mcwp_pkg::*; #(
  parameter int                 BITMAP_WORDS = 256,
  parameter logic signed [31:0] X_LOW        = 0,
  parameter logic signed [31:0] Y_LOW        = 0,
  parameter logic signed [31:0] Z_LOW        = 0,
  parameter logic signed [31:0] Z_HIGH       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Command word channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   word_i,
  // Request channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 kind_o,
  output logic [1:0]           action_type_o,
  output logic signed [31:0]   target_x_o,
  output logic signed [31:0]   target_y_o,
  output logic signed [31:0]   target_z_o,
  output logic [19:0]          path_rate_o,
  output logic signed [31:0]   laser_power_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  // Configuration registers.
  logic [SPEED_W-1:0] base_speed_q, bitmap_speed_q;
  coord_t             off_x_q, off_y_q, off_z_q;
  logic               clamp_en_q;
  coord_t             clamp_max_x_q, clamp_max_y_q;

  // Input register.
  logic   inq_valid_q;
  coord_t word_q;
  logic   proc_fire;

  // Parser state.
  logic [STEP_W-1:0] step_q, step_d;
  cmd_e              cmd_q, cmd_d;
  coord_t            arg_x_q, arg_x_d, arg_y_q, arg_y_d;
  set_sel_e          set_sel_q, set_sel_d;
  coord_t            power_q, power_d;
  coord_t            plan_x_q, plan_x_d, plan_y_q, plan_y_d, plan_z_q, plan_z_d;
  logic [BPP_W-1:0]  bpp_q, bpp_d;
  logic [STEP_W-1:0] bm_words_q, bm_words_d;
  logic              bm_pending_q, bm_pending_d;

  // Result register.
  logic              out_valid_q;
  kind_e             kind_q;
  act_e              act_q;
  coord_t            tx_q, ty_q, tz_q;
  logic [FEED_W-1:0] feed_q;
  coord_t            pwr_q;

  // Datapath.
  coord_t             raw_x, raw_y_move, raw_y_set, raw_z;
  coord_t             mv_x, mv_y, mv_z, cl_x, cl_y, cl_z;
  logic [SPEED_W-1:0] line_speed, sel_speed;
  logic [FEED_W-1:0]  move_feed;
  logic [WORD_W-1:0]  bm_prod;
  logic [STEP_W-1:0]  bm_ceil;
  logic [SPEED_W-1:0] sat_pct;
  speed_req_t         speed_req, speed_req_fire;
  logic               bm_we, bm_start;

  logic              emit;
  kind_e             emit_kind;
  act_e              emit_act;
  coord_t            emit_x, emit_y, emit_z, emit_power;
  logic [FEED_W-1:0] emit_feed;

  // Configuration writes.
  assign cfg_ready_o = !inq_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q   <= SPEED_RESET;
      bitmap_speed_q <= SPEED_RESET;
      off_x_q        <= '0;
      off_y_q        <= '0;
      off_z_q        <= '0;
      clamp_en_q     <= 1'b0;
      clamp_max_x_q  <= CLAMP_MAX_RESET;
      clamp_max_y_q  <= CLAMP_MAX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BASE_SPEED:   base_speed_q   <= cfg_data_i[SPEED_W-1:0];
        REG_BITMAP_SPEED: bitmap_speed_q <= cfg_data_i[SPEED_W-1:0];
        REG_OFFSET_X:     off_x_q        <= cfg_data_i;
        REG_OFFSET_Y:     off_y_q        <= cfg_data_i;
        REG_OFFSET_Z:     off_z_q        <= cfg_data_i;
        REG_CLAMP_EN:     clamp_en_q     <= cfg_data_i[0];
        REG_CLAMP_MAX_X:  clamp_max_x_q  <= cfg_data_i;
        REG_CLAMP_MAX_Y:  clamp_max_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The parser moves on whenever the result register is free or being read.
  assign proc_fire  = inq_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !inq_valid_q || proc_fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      inq_valid_q <= 1'b1;
    end else if (proc_fire) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= word_i;
    end
  end

  // Relative to absolute coordinates.
  assign raw_x      = arg_x_q - off_x_q;
  assign raw_y_move = word_q - off_y_q;
  assign raw_y_set  = arg_y_q - off_y_q;
  assign raw_z      = word_q - off_z_q;

  // A z move keeps the planned x and y; a travel or line keeps the planned z.
  always_comb begin
    if (cmd_q == CMD_ZMOVE) begin
      mv_x = plan_x_q;
      mv_y = plan_y_q;
      mv_z = raw_z;
    end else begin
      mv_x = raw_x;
      mv_y = raw_y_move;
      mv_z = plan_z_q;
    end
  end

  mcwp_clamp #(
    .X_LOW  (X_LOW),
    .Y_LOW  (Y_LOW),
    .Z_LOW  (Z_LOW),
    .Z_HIGH (Z_HIGH)
  ) u_clamp (
    .enable_i (clamp_en_q),
    .max_x_i  (clamp_max_x_q),
    .max_y_i  (clamp_max_y_q),
    .x_i      (mv_x),
    .y_i      (mv_y),
    .z_i      (mv_z),
    .x_o      (cl_x),
    .y_o      (cl_y),
    .z_o      (cl_z)
  );

  // Feed rate in mm per minute.
  assign move_feed = FEED_W'(sel_speed) * FEED_W'(FEED_SCALE);

  // Bitmap size in words, rounded up.
  assign bm_prod = WORD_W'(bpp_q) * word_q;
  assign bm_ceil = STEP_W'(bm_prod[WORD_W-1:BITS_PER_WORD_LOG2])
                 + STEP_W'(|bm_prod[BITS_PER_WORD_LOG2-1:0]);

  // Mark speed percentage saturated to its legal range.
  always_comb begin
    if (word_q < SPEED_PCT_MIN) begin
      sat_pct = SPEED_W'(1);
    end else if (word_q > SPEED_PCT_SAT) begin
      sat_pct = SPEED_PCT_FULL;
    end else begin
      sat_pct = word_q[SPEED_W-1:0];
    end
  end

  // Parser step for the word in the input register.
  always_comb begin
    step_d       = step_q;
    cmd_d        = cmd_q;
    arg_x_d      = arg_x_q;
    arg_y_d      = arg_y_q;
    set_sel_d    = set_sel_q;
    power_d      = power_q;
    plan_x_d     = plan_x_q;
    plan_y_d     = plan_y_q;
    plan_z_d     = plan_z_q;
    bpp_d        = bpp_q;
    bm_words_d   = bm_words_q;
    bm_pending_d = bm_pending_q;
    sel_speed    = base_speed_q;
    emit         = 1'b0;
    emit_kind    = KIND_MOVE;
    emit_act     = ACT_TRAVEL;
    emit_x       = cl_x;
    emit_y       = cl_y;
    emit_z       = cl_z;
    emit_feed    = move_feed;
    emit_power   = power_q;
    speed_req    = '{load: 1'b0, percent: sat_pct, base: base_speed_q};
    bm_we        = 1'b0;
    bm_start     = 1'b0;

    if (step_q == '0) begin
      cmd_d  = decode_cmd(word_q);
      step_d = STEP_W'(1);
    end else begin
      case (cmd_q)
        CMD_TRAVEL, CMD_LINE: begin
          if (step_q == STEP_W'(1)) begin
            arg_x_d = word_q;
            step_d  = STEP_W'(2);
          end else begin
            emit     = 1'b1;
            step_d   = '0;
            plan_x_d = cl_x;
            plan_y_d = cl_y;
            plan_z_d = cl_z;
            if (cmd_q == CMD_LINE) begin
              if (bm_pending_q) begin
                emit_act     = ACT_BITMAP;
                bm_pending_d = 1'b0;
                sel_speed    = bitmap_speed_q;
              end else begin
                emit_act  = ACT_LINE;
                sel_speed = line_speed;
              end
            end
          end
        end
        CMD_ZMOVE: begin
          emit     = 1'b1;
          step_d   = '0;
          plan_x_d = cl_x;
          plan_y_d = cl_y;
          plan_z_d = cl_z;
        end
        CMD_SETPOS: begin
          if (step_q == STEP_W'(1)) begin
            arg_x_d = word_q;
            step_d  = STEP_W'(2);
          end else if (step_q == STEP_W'(2)) begin
            arg_y_d = word_q;
            step_d  = STEP_W'(3);
          end else begin
            emit       = 1'b1;
            step_d     = '0;
            emit_kind  = KIND_SETPOS;
            emit_x     = raw_x;
            emit_y     = raw_y_set;
            emit_z     = raw_z;
            emit_feed  = '0;
            emit_power = '0;
            plan_x_d   = raw_x;
            plan_y_d   = raw_y_set;
            plan_z_d   = raw_z;
          end
        end
        CMD_SETTING: begin
          if (step_q == STEP_W'(1)) begin
            if (word_q == SET_IDX_SPEED) begin
              set_sel_d = SEL_SPEED;
            end else if (word_q == SET_IDX_POWER) begin
              set_sel_d = SEL_POWER;
            end else begin
              set_sel_d = SEL_NONE;
            end
            step_d = STEP_W'(2);
          end else begin
            step_d = '0;
            if (set_sel_q == SEL_SPEED) begin
              speed_req.load = 1'b1;
            end else if (set_sel_q == SEL_POWER) begin
              power_d = word_q;
            end
          end
        end
        CMD_BITMAP: begin
          if (step_q == STEP_W'(1)) begin
            bpp_d  = word_q[BPP_W-1:0];
            step_d = STEP_W'(2);
          end else if (step_q == STEP_W'(2)) begin
            bm_words_d   = bm_ceil;
            bm_pending_d = 1'b1;
            bm_start     = 1'b1;
            // An empty bitmap ends the load at once.
            step_d       = (bm_ceil == '0) ? '0 : STEP_W'(3);
          end else begin
            bm_we  = 1'b1;
            step_d = ((step_q - STEP_W'(2)) == bm_words_q) ? '0 : step_q + STEP_W'(1);
          end
        end
        default: begin
          // Code 5 and unknown codes drop one argument word.
          step_d = '0;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= '0;
      cmd_q        <= CMD_TRAVEL;
      arg_x_q      <= '0;
      arg_y_q      <= '0;
      set_sel_q    <= SEL_NONE;
      power_q      <= POWER_RESET;
      plan_x_q     <= '0;
      plan_y_q     <= '0;
      plan_z_q     <= '0;
      bpp_q        <= BPP_RESET;
      bm_words_q   <= '0;
      bm_pending_q <= 1'b0;
    end else if (proc_fire) begin
      step_q       <= step_d;
      cmd_q        <= cmd_d;
      arg_x_q      <= arg_x_d;
      arg_y_q      <= arg_y_d;
      set_sel_q    <= set_sel_d;
      power_q      <= power_d;
      plan_x_q     <= plan_x_d;
      plan_y_q     <= plan_y_d;
      plan_z_q     <= plan_z_d;
      bpp_q        <= bpp_d;
      bm_words_q   <= bm_words_d;
      bm_pending_q <= bm_pending_d;
    end
  end

  // Only a word that is actually consumed may load a new mark speed.
  always_comb begin
    speed_req_fire      = speed_req;
    speed_req_fire.load = speed_req.load && proc_fire;
  end

  mcwp_speed_scale u_speed_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (speed_req_fire),
    .line_speed_o (line_speed)
  );

  mcwp_bitmap_store #(
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bm_start && proc_fire),
    .we_i    (bm_we && proc_fire),
    .data_i  (word_q)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && emit) begin
      kind_q <= emit_kind;
      act_q  <= emit_act;
      tx_q   <= emit_x;
      ty_q   <= emit_y;
      tz_q   <= emit_z;
      feed_q <= emit_feed;
      pwr_q  <= emit_power;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign action_type_o = act_q;
  assign target_x_o    = tx_q;
  assign target_y_o    = ty_q;
  assign target_z_o    = tz_q;
  assign path_rate_o   = feed_q;
  assign laser_power_o = pwr_q;

  // A set-position request carries no feed, power or action.
  a_setpos_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_SETPOS)) |->
      ((path_rate_o == '0) && (laser_power_o == '0) && (action_type_o == ACT_TRAVEL)))
    else $error("set-position item with nonzero feed, power or action");

  // A bitmap line consumes the pending bitmap.
  a_bitmap_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && emit && (emit_act == ACT_BITMAP)) |=> !bm_pending_q)
    else $error("bitmap still pending after a bitmap line");

  // Two-argument line commands never run past their second argument.
  a_line_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_q == CMD_TRAVEL) || (cmd_q == CMD_LINE)) |-> (step_q <= STEP_W'(2)))
    else $error("line command step counter out of range");

  // A skipped code drops exactly one word.
  a_skip_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q == CMD_SKIP) |-> (step_q <= STEP_W'(1)))
    else $error("skip command held more than one word");

endmodule
